FILE: rtl/core/hpq_pkg.sv
// Shared types and constants of the max-heap priority queue.
package hpq_pkg;

  localparam int unsigned HPQ_CAPACITY = 63;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned COUNT_OUT_W = 6;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    op_e                      op;
    logic signed [DATA_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] removed_value;
    logic signed [DATA_W-1:0] top_value;
    logic [COUNT_OUT_W-1:0]   entry_count;
    status_e                  status;
  } rsp_t;

endpackage

FILE: rtl/core/hpq_if.sv
// Valid/ready channel interfaces for request and response words of the heap queue.
interface hpq_req_if import hpq_pkg::*; ();
  logic valid;
  logic ready;
  req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface hpq_rsp_if import hpq_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

FILE: rtl/core/hpq_ram.sv
// Generic RAM with one write port and two registered read ports.
module hpq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_a_i,
  input  logic [AW-1:0]    raddr_b_i,
  output logic [WIDTH-1:0] rdata_a_o,
  output logic [WIDTH-1:0] rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

FILE: rtl/core/max_heap_priority_queue.sv
// Binary max-heap priority queue of signed 32-bit values kept in a RAM.
//
// Requests arrive on req_i: op selects insert or remove of the maximum,
// value is the word to insert. Every request yields exactly one word on
// rsp_o with the removed value, the new maximum, the entry count and a
// status (ok, remove on empty, insert on full). Both channels accept a
// word when valid and ready are high at a rising edge of clk_i.
// One request is worked on at a time. An insert moves the value up and a
// remove sinks the entry moved from the last place down, one heap level
// per single RAM read-compare-write step. A rejected request, an insert
// into an empty heap and a remove of the only entry go straight to the
// result, and a remove that leaves one entry only moves the last entry.
// The next request is taken in the cycle after the result is registered.
// The result sits in an output register, so the next request is taken
// while it waits; the block only stalls in its final cycle when that
// register still holds a word that has not been taken.
// rst_ni clears the count and the handshake state at once; the heap RAM
// is not cleared and needs no clearing pass.
module max_heap_priority_queue import hpq_pkg::*; #(
  parameter int unsigned CAPACITY = HPQ_CAPACITY
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  hpq_req_if.sink    req_i,
  hpq_rsp_if.source  rsp_o
);

  localparam int unsigned DEPTH = CAPACITY + 1;
  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned IW = AW + 1;

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_UP      = 6'b000010,
    S_DN_LAST = 6'b000100,
    S_DN      = 6'b001000,
    S_WR      = 6'b010000,
    S_FIN     = 6'b100000
  } state_e;

  state_e                   state_q, state_d;
  logic [AW-1:0]            count_q, count_d;
  logic [AW-1:0]            pos_q, pos_d;
  logic signed [DATA_W-1:0] top_q, top_d;
  logic signed [DATA_W-1:0] val_q, val_d;
  logic signed [DATA_W-1:0] removed_q, removed_d;
  status_e                  status_q, status_d;
  logic                     out_valid_q, out_valid_d;
  rsp_t                     out_q, out_d;

  logic                     wr_en;
  logic [AW-1:0]            wr_addr;
  logic signed [DATA_W-1:0] wr_data;
  logic                     rd_issue;
  logic [AW-1:0]            ra_addr, rb_addr;
  logic signed [DATA_W-1:0] ra_data, rb_data;

  logic [IW-1:0]            count_ext, left_idx, right_idx, best_left;
  logic [AW-1:0]            cnt_inc, parent_pos, best_pos;
  logic                     right_present, take_l, take_r;
  logic signed [DATA_W-1:0] cand, best_val;
  logic                     req_acc;

  hpq_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i     (clk_i),
    .we_i      (wr_en),
    .waddr_i   (wr_addr),
    .wdata_i   (wr_data),
    .raddr_a_i (ra_addr),
    .raddr_b_i (rb_addr),
    .rdata_a_o (ra_data),
    .rdata_b_o (rb_data)
  );

  assign req_i.ready   = (state_q == S_IDLE);
  assign req_acc       = req_i.valid && req_i.ready;
  assign rsp_o.valid   = out_valid_q;
  assign rsp_o.payload = out_q;

  assign count_ext     = IW'(count_q);
  assign left_idx      = {pos_q, 1'b0};
  assign right_idx     = {pos_q, 1'b1};
  assign right_present = (right_idx <= count_ext);
  assign cnt_inc       = count_q + AW'(1);
  assign parent_pos    = pos_q >> 1;

  assign take_l    = (ra_data > val_q);
  assign cand      = take_l ? ra_data : val_q;
  assign take_r    = right_present && (rb_data > cand);
  assign best_pos  = take_r ? right_idx[AW-1:0] : left_idx[AW-1:0];
  assign best_val  = take_r ? rb_data : ra_data;
  assign best_left = {best_pos, 1'b0};

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    pos_d       = pos_q;
    val_d       = val_q;
    removed_d   = removed_q;
    status_d    = status_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !rsp_o.ready;
    wr_en       = 1'b0;
    wr_addr     = pos_q;
    wr_data     = val_q;
    rd_issue    = 1'b0;
    ra_addr     = '0;
    rb_addr     = '0;

    case (state_q)
      S_IDLE: begin
        if (req_acc) begin
          removed_d = '0;
          status_d  = ST_OK;
          state_d   = S_FIN;
          if (req_i.payload.op == OP_INSERT) begin
            if (count_q == AW'(CAPACITY)) begin
              status_d = ST_FULL;
            end else begin
              count_d = cnt_inc;
              pos_d   = cnt_inc;
              val_d   = req_i.payload.value;
              if (count_q == '0) begin
                wr_en   = 1'b1;
                wr_addr = AW'(1);
                wr_data = req_i.payload.value;
              end else begin
                rd_issue = 1'b1;
                ra_addr  = cnt_inc >> 1;
                state_d  = S_UP;
              end
            end
          end else begin
            if (count_q == '0) begin
              status_d = ST_EMPTY;
            end else begin
              removed_d = top_q;
              count_d   = count_q - AW'(1);
              if (count_q != AW'(1)) begin
                rd_issue = 1'b1;
                ra_addr  = count_q;
                state_d  = S_DN_LAST;
              end
            end
          end
        end
      end
      S_UP: begin
        if (val_q > ra_data) begin
          wr_en   = 1'b1;
          wr_addr = pos_q;
          wr_data = ra_data;
          pos_d   = parent_pos;
          if (parent_pos == AW'(1)) begin
            state_d = S_WR;
          end else begin
            rd_issue = 1'b1;
            ra_addr  = parent_pos >> 1;
          end
        end else begin
          wr_en   = 1'b1;
          state_d = S_FIN;
        end
      end
      S_DN_LAST: begin
        val_d = ra_data;
        pos_d = AW'(1);
        if (count_ext < IW'(2)) begin
          wr_en   = 1'b1;
          wr_addr = AW'(1);
          wr_data = ra_data;
          state_d = S_FIN;
        end else begin
          rd_issue = 1'b1;
          ra_addr  = AW'(2);
          rb_addr  = AW'(3);
          state_d  = S_DN;
        end
      end
      S_DN: begin
        wr_en = 1'b1;
        if (take_l || take_r) begin
          wr_data = best_val;
          pos_d   = best_pos;
          if (best_left > count_ext) begin
            state_d = S_WR;
          end else begin
            rd_issue = 1'b1;
            ra_addr  = best_left[AW-1:0];
            rb_addr  = AW'(best_left + IW'(1));
          end
        end else begin
          state_d = S_FIN;
        end
      end
      S_WR: begin
        wr_en   = 1'b1;
        state_d = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_d.removed_value = removed_q;
          out_d.top_value     = (count_q != '0) ? top_q : '0;
          out_d.entry_count   = COUNT_OUT_W'(count_q);
          out_d.status        = status_q;
          out_valid_d         = 1'b1;
          state_d             = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    top_d = top_q;
    if (wr_en && (wr_addr == AW'(1))) begin
      top_d = wr_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q     <= pos_d;
    top_q     <= top_d;
    val_q     <= val_d;
    removed_q <= removed_d;
    status_q  <= status_d;
    out_q     <= out_d;
  end

  // A read never targets the entry that is written in the same cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd_issue && wr_en) |-> ((ra_addr != wr_addr) && (rb_addr != wr_addr)))
    else $error("heap RAM read and write collide on one entry");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= AW'(CAPACITY))
    else $error("heap count exceeds capacity");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |=> $stable(count_q))
    else $error("heap count changed while a request was in progress");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_acc |=> (state_q != S_IDLE))
    else $error("accepted request did not start work");

endmodule

FILE: test/max_heap_priority_queue_test.sv
// Randomized self-checking testbench of the max-heap priority queue against a local heap mirror.
`timescale 1ns / 100ps

module max_heap_priority_queue_test;
  import hpq_pkg::*;

  localparam int unsigned IDLE_LIMIT = 2000;
  localparam int unsigned HOLD_START = 1500;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned RANDOM_WORDS = 1400;
  localparam int unsigned PRINT_LIMIT = 40;

  logic clk_i = 1'b0;
  logic rst_ni;

  hpq_req_if req_if ();
  hpq_rsp_if rsp_if ();

  max_heap_priority_queue u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  always #6 clk_i = ~clk_i;

  req_t request_q[$];
  rsp_t awaited_rsp_q[$];
  logic signed [DATA_W-1:0] mirror_heap [1:HPQ_CAPACITY];
  int unsigned mirror_count = 0;
  int unsigned planned_count;
  int unsigned total_words;
  int unsigned words_sent;
  int unsigned fail_count = 0;
  int unsigned burst_left;
  int unsigned gap_left;
  int unsigned rx_cycle;
  int unsigned hold_left;
  int unsigned idle_cycles = 0;

  function automatic rsp_t heap_apply(req_t r);
    rsp_t o;
    int unsigned pos;
    int unsigned parent;
    int unsigned left;
    int unsigned best;
    logic signed [DATA_W-1:0] t;
    o = '0;
    o.status = ST_OK;
    if (r.op == OP_INSERT) begin
      if (mirror_count >= HPQ_CAPACITY) begin
        o.status = ST_FULL;
      end else begin
        mirror_count++;
        mirror_heap[mirror_count] = r.value;
        pos = mirror_count;
        while (pos > 1) begin
          parent = pos >> 1;
          if (mirror_heap[pos] <= mirror_heap[parent]) break;
          t = mirror_heap[pos];
          mirror_heap[pos] = mirror_heap[parent];
          mirror_heap[parent] = t;
          pos = parent;
        end
      end
    end else begin
      if (mirror_count == 0) begin
        o.status = ST_EMPTY;
      end else begin
        o.removed_value = mirror_heap[1];
        mirror_heap[1] = mirror_heap[mirror_count];
        mirror_count--;
        pos = 1;
        while (mirror_count > 1) begin
          left = pos * 2;
          best = pos;
          if (left <= mirror_count && mirror_heap[left] > mirror_heap[best]) best = left;
          if (left + 1 <= mirror_count && mirror_heap[left + 1] > mirror_heap[best]) begin
            best = left + 1;
          end
          if (best == pos) break;
          t = mirror_heap[pos];
          mirror_heap[pos] = mirror_heap[best];
          mirror_heap[best] = t;
          pos = best;
        end
      end
    end
    o.top_value = (mirror_count > 0) ? mirror_heap[1] : '0;
    o.entry_count = mirror_count[COUNT_OUT_W-1:0];
    return o;
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_value();
    logic signed [DATA_W-1:0] v;
    case ($urandom_range(0, 9))
      6, 7: v = int'($urandom_range(0, 8)) - 4;
      8: begin
        case ($urandom_range(0, 3))
          0: v = 32'sh7FFF_FFFF;
          1: v = 32'sh8000_0000;
          2: v = '0;
          default: v = -1;
        endcase
      end
      9: begin
        if ($urandom_range(0, 1) == 1) v = 32'sh7FFF_FFFF - int'($urandom_range(1, 3));
        else v = 32'sh8000_0000 + int'($urandom_range(1, 3));
      end
      default: v = $urandom;
    endcase
    return v;
  endfunction

  task automatic add_word(op_e op, logic signed [DATA_W-1:0] value);
    req_t r;
    r.op = op;
    r.value = value;
    request_q.push_back(r);
    if (op == OP_INSERT && planned_count < HPQ_CAPACITY) planned_count++;
    if (op == OP_REMOVE && planned_count > 0) planned_count--;
  endtask

  task automatic report_mismatch(string field, logic [DATA_W-1:0] got,
                                 logic [DATA_W-1:0] want);
    fail_count++;
    if (fail_count <= PRINT_LIMIT) begin
      $display("%0t ns: %s is %h, expected %h", $time, field, got, want);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
      req_if.payload <= '0;
      burst_left <= 0;
      gap_left <= 0;
      words_sent <= 0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        awaited_rsp_q.push_back(heap_apply(req_if.payload));
        words_sent <= words_sent + 1;
      end
      if (!req_if.valid || req_if.ready) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          req_if.valid <= 1'b0;
        end else if (request_q.size() != 0) begin
          req_if.valid <= 1'b1;
          req_if.payload <= request_q.pop_front();
          if (burst_left <= 1) begin
            case ($urandom_range(0, 9))
              0, 1: begin
                burst_left <= $urandom_range(100, 200);
                gap_left <= 0;
              end
              2, 3, 4: begin
                burst_left <= $urandom_range(10, 40);
                gap_left <= $urandom_range(0, 12);
              end
              default: begin
                burst_left <= $urandom_range(1, 8);
                gap_left <= $urandom_range(0, 6);
              end
            endcase
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
      rx_cycle <= 0;
      hold_left <= 0;
    end else begin
      rx_cycle <= rx_cycle + 1;
      if (rx_cycle == HOLD_START) begin
        hold_left <= HOLD_CYCLES;
        rsp_if.ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        rsp_if.ready <= 1'b0;
      end else begin
        case (rx_cycle[8:7])
          2'd0: rsp_if.ready <= 1'b1;
          2'd1: rsp_if.ready <= ($urandom_range(0, 3) != 0);
          2'd2: rsp_if.ready <= ($urandom_range(0, 3) == 0);
          default: rsp_if.ready <= rx_cycle[2];
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    rsp_t want;
    rsp_t got;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      got = rsp_if.payload;
      if (awaited_rsp_q.size() == 0) begin
        report_mismatch("unexpected word, top_value", got.top_value, '0);
      end else begin
        want = awaited_rsp_q.pop_front();
        if (got.removed_value !== want.removed_value) begin
          report_mismatch("removed_value", got.removed_value, want.removed_value);
        end
        if (got.top_value !== want.top_value) begin
          report_mismatch("top_value", got.top_value, want.top_value);
        end
        if (got.entry_count !== want.entry_count) begin
          report_mismatch("entry_count", 32'(got.entry_count), 32'(want.entry_count));
        end
        if (got.status !== want.status) begin
          report_mismatch("status", 32'(got.status), 32'(want.status));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("max_heap_priority_queue: mismatch");
        $finish;
      end
    end
  end

  initial begin
    int unsigned target;
    rst_ni = 1'b0;
    planned_count = 0;

    add_word(OP_REMOVE, 32'sh1234_5678);
    add_word(OP_INSERT, 32'sh8000_0000);
    add_word(OP_INSERT, 32'sh7FFF_FFFF);
    add_word(OP_INSERT, '0);
    add_word(OP_INSERT, -1);
    add_word(OP_INSERT, 5);
    add_word(OP_INSERT, 5);
    add_word(OP_INSERT, 5);
    add_word(OP_INSERT, 7);
    add_word(OP_INSERT, 5);
    repeat (9) add_word(OP_REMOVE, $urandom);
    add_word(OP_REMOVE, 32'sh7FFF_FFFF);

    while (request_q.size() < RANDOM_WORDS + 20) begin
      if ($urandom_range(0, 9) < 4) begin
        target = HPQ_CAPACITY - planned_count + $urandom_range(0, 3);
        repeat (target) add_word(OP_INSERT, pick_value());
        target = planned_count + $urandom_range(0, 2);
        repeat (target) add_word(OP_REMOVE, $urandom);
      end else begin
        target = $urandom_range(1, 3);
        repeat ($urandom_range(20, 60)) begin
          if ($urandom_range(0, 3) < target) add_word(OP_INSERT, pick_value());
          else add_word(OP_REMOVE, $urandom);
        end
      end
    end
    total_words = request_q.size();

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (words_sent != total_words) @(posedge clk_i);
    while (awaited_rsp_q.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("max_heap_priority_queue: match");
    end else begin
      $display("max_heap_priority_queue: mismatch");
    end
    $finish;
  end

endmodule
